// ===== rtl/nsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

	// fixed field widths
	localparam int ROOT_WIDTH      = 24;
	localparam int STEPS_WIDTH     = 8;
	localparam int TOL_WIDTH       = 16;
	localparam int ITER_WIDTH      = 8;
	localparam int OUT_TDATA_WIDTH = 32;

	// quotient saturation point is 2**QUOT_CAP_LOG2
	localparam int QUOT_CAP_LOG2 = 60;

	// configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE      = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_ITERATIONS = 2'd1;

	localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET      = 16'd7;
	localparam logic [ITER_WIDTH-1:0] MAX_ITERATIONS_RESET = 8'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOP,
		ST_DIV,
		ST_SUM,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/nsr_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) / divisor
module nsr_divider
	import nsr_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter int GUESS_WIDTH = 61
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [GUESS_WIDTH-1:0] divisor,
	output logic                        done,
	output logic [GUESS_WIDTH-1:0]      quotient
);

	localparam int DIV_WIDTH = VALUE_WIDTH + FRAC_BITS;
	localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);
	localparam logic [GUESS_WIDTH-1:0] QUOT_CAP = GUESS_WIDTH'(1) << QUOT_CAP_LOG2;

	// dividend bits shift out the top while quotient bits shift in the bottom
	logic [DIV_WIDTH-1:0]   shreg_q;
	logic [GUESS_WIDTH-1:0] rem_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic                   busy_q;

	logic [GUESS_WIDTH:0]   rem_sh;
	logic [GUESS_WIDTH:0]   rem_sub;
	logic                   ge;
	logic [GUESS_WIDTH-1:0] quot_ext;

	assign rem_sh  = {rem_q, shreg_q[DIV_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign ge      = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_WIDTH'(DIV_WIDTH);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= {dividend, {FRAC_BITS{1'b0}}};
			rem_q   <= '0;
		end else if (busy_q && cnt_q != '0) begin
			shreg_q <= {shreg_q[DIV_WIDTH-2:0], ge};
			rem_q   <= ge ? rem_sub[GUESS_WIDTH-1:0] : rem_sh[GUESS_WIDTH-1:0];
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quot_ext = GUESS_WIDTH'(shreg_q);
	assign quotient = (quot_ext > QUOT_CAP) ? QUOT_CAP : quot_ext;

endmodule

`default_nettype wire

// ===== rtl/newton_square_root_unit.sv =====
// each newton step passes ST_TOP, the bit-serial divide in ST_DIV, ST_SUM and
//   ST_CHECK; negative or tiny inputs skip the divider and go from ST_TOP straight
//   to ST_FINISH, which loads the output register once it is free and returns to idle
// throughput: one item at a time, the bit-serial divider sets the per-step cost
// a finished result waits in the output register while the next item is taken
// reset: arst_n clears control state and loads tolerance 7, max_iterations 100
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root_unit
	import nsr_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,  // value
	// result stream
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [OUT_TDATA_WIDTH-1:0]             m_axis_tdata,  // root, steps_used
	output logic                                   m_axis_tuser,  // status
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]         cfg_data
);

	localparam int DIV_WIDTH   = VALUE_WIDTH + FRAC_BITS;
	// guess and quotient width: wide enough for the saturated quotient
	localparam int GUESS_WIDTH = (DIV_WIDTH > QUOT_CAP_LOG2 + 1) ? DIV_WIDTH
	                                                             : QUOT_CAP_LOG2 + 1;

	state_t state_q, state_d;

	// configuration registers
	logic [TOL_WIDTH-1:0]   tol_q;
	logic [ITER_WIDTH-1:0]  max_iter_q;

	// working registers
	logic [VALUE_WIDTH-1:0] raw_q;
	logic [GUESS_WIDTH-1:0] guess_q;
	logic [GUESS_WIDTH-1:0] next_q;
	logic [STEPS_WIDTH-1:0] steps_q;
	logic                   neg_q;

	// output register
	logic                   out_valid_q;
	logic [ROOT_WIDTH-1:0]  out_root_q;
	logic [STEPS_WIDTH-1:0] out_steps_q;
	logic                   out_status_q;

	logic                   in_xfer;
	logic                   out_free;
	logic                   stop_iter;
	logic                   converged;
	logic                   div_start;
	logic                   div_done;
	logic                   load_out;
	logic [GUESS_WIDTH-1:0] quot;
	logic [GUESS_WIDTH:0]   sum;
	logic [GUESS_WIDTH-1:0] delta;
	logic [ROOT_WIDTH-1:0]  root_sat;
	logic                   in_neg;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign in_neg   = s_axis_tdata[VALUE_WIDTH-1];

	// loop exit at the head of a step: budget spent or guess collapsed to zero
	assign stop_iter = (steps_q >= max_iter_q) || (guess_q == '0);

	assign sum       = {1'b0, guess_q} + {1'b0, quot};
	assign delta     = (next_q >= guess_q) ? (next_q - guess_q) : (guess_q - next_q);
	assign converged = delta < GUESS_WIDTH'(tol_q);

	assign root_sat = (|guess_q[GUESS_WIDTH-1:ROOT_WIDTH]) ? {ROOT_WIDTH{1'b1}}
	                                                       : guess_q[ROOT_WIDTH-1:0];

	nsr_divider #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.GUESS_WIDTH (GUESS_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_q),
		.divisor  (guess_q),
		.done     (div_done),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_TOP;
			end
			ST_TOP: begin
				state_d = stop_iter ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = converged ? ST_FINISH : ST_TOP;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_TOP:    div_start     = !stop_iter;
			ST_FINISH: load_out      = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers, written only while idle
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOLERANCE_RESET;
			max_iter_q <= MAX_ITERATIONS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOLERANCE:      tol_q      <= cfg_data[TOL_WIDTH-1:0];
				REG_MAX_ITERATIONS: max_iter_q <= cfg_data[ITER_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// newton datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			raw_q   <= s_axis_tdata[VALUE_WIDTH-1:0];
			neg_q   <= in_neg;
			steps_q <= '0;
			// first guess is value/2; a negative input starts from zero and exits at once
			guess_q <= in_neg ? '0 : GUESS_WIDTH'(s_axis_tdata[VALUE_WIDTH-1:1]);
		end else if (state_q == ST_SUM) begin
			next_q  <= sum[GUESS_WIDTH:1];
			steps_q <= steps_q + 1'b1;
		end else if (state_q == ST_CHECK && !converged) begin
			guess_q <= next_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_root_q   <= root_sat;
			out_steps_q  <= steps_q;
			out_status_q <= neg_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_steps_q, out_root_q};
	assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/nsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsr_checker
	import nsr_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	input wire logic                       m_axis_tuser
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a rejected input reports zero root and no steps
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("rejected input with nonzero root or steps");

	// one item at a time: input side closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second input taken while busy");

	// no result can appear the cycle right after an input transfer
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too early");

endmodule

bind newton_square_root_unit nsr_checker u_nsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import nsr_pkg::*;

	// block configuration under test, the defaults of the unit
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 16;
	localparam int IN_BYTES_W = ((VALUE_W + 7) / 8) * 8;

	// longest stretch with no transfer at all: a 255-step item, taken several times over
	localparam int IDLE_LIMIT = 60000;

	typedef struct packed {
		logic [ROOT_WIDTH-1:0]  root;
		logic                   status;
		logic [STEPS_WIDTH-1:0] steps;
	} sqrt_result_t;

	// expected roots in arrival order, plus a private copy of the registers
	class sqrt_scoreboard;
		localparam logic [63:0] QUOT_CAP = 64'd1 << QUOT_CAP_LOG2;
		localparam logic [63:0] ROOT_MAX = (64'd1 << ROOT_WIDTH) - 64'd1;

		logic [TOL_WIDTH-1:0]  tolerance;
		logic [ITER_WIDTH-1:0] max_iterations;
		sqrt_result_t          pending_roots[$];
		int                    failures;
		int                    mismatches;

		function new();
			tolerance      = TOLERANCE_RESET;
			max_iterations = MAX_ITERATIONS_RESET;
			failures       = 0;
			mismatches     = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_WIDTH-1:0] index,
				logic [CFG_DATA_WIDTH-1:0] data);
			if (index == REG_TOLERANCE)
				tolerance = data[TOL_WIDTH-1:0];
			else if (index == REG_MAX_ITERATIONS)
				max_iterations = data[ITER_WIDTH-1:0];
		endfunction

		// (dividend << FRAC_W) / divisor, restoring, bit by bit, saturating
		function logic [63:0] scaled_quotient(logic [63:0] dividend, logic [63:0] divisor);
			logic [63:0] rem;
			logic [63:0] quo;
			logic [63:0] bitv;
			logic        sat;
			rem = '0;
			quo = '0;
			sat = 1'b0;
			for (int i = VALUE_W + FRAC_W - 1; i >= 0; i--) begin
				bitv = (i >= FRAC_W) ? ((dividend >> (i - FRAC_W)) & 64'd1) : 64'd0;
				rem  = (rem << 1) | bitv;
				bitv = 64'd0;
				if (rem >= divisor) begin
					rem  = rem - divisor;
					bitv = 64'd1;
				end
				if (!sat) begin
					quo = (quo << 1) | bitv;
					if (quo > QUOT_CAP)
						sat = 1'b1;
				end
			end
			return sat ? QUOT_CAP : quo;
		endfunction

		function sqrt_result_t newton_root(logic [VALUE_W-1:0] raw);
			sqrt_result_t r;
			logic [63:0]  guess;
			logic [63:0]  quo;
			logic [63:0]  nxt;
			logic [63:0]  diff;
			r = '0;
			if (raw[VALUE_W-1]) begin
				r.status = 1'b1;
			end else if ((raw >> 1) != 0) begin
				guess = {32'd0, raw} >> 1;
				for (int n = 0; n < int'(max_iterations); n++) begin
					if (guess == 64'd0)
						break;
					quo  = scaled_quotient({32'd0, raw}, guess);
					nxt  = (guess + quo) >> 1;
					r.steps = r.steps + 1'b1;
					diff = (nxt >= guess) ? nxt - guess : guess - nxt;
					if (diff < {48'd0, tolerance})
						break;
					guess = nxt;
				end
				r.root = (guess > ROOT_MAX) ? ROOT_MAX[ROOT_WIDTH-1:0] : guess[ROOT_WIDTH-1:0];
			end
			return r;
		endfunction

		function void note_operand(logic [VALUE_W-1:0] raw);
			pending_roots.push_back(newton_root(raw));
		endfunction

		function void check_result(logic [OUT_TDATA_WIDTH-1:0] tdata, logic tuser);
			sqrt_result_t want;
			sqrt_result_t got;
			got.root   = tdata[ROOT_WIDTH-1:0];
			got.steps  = tdata[ROOT_WIDTH +: STEPS_WIDTH];
			got.status = tuser;
			if (pending_roots.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: root %0d status %0d steps %0d",
						got.root, got.status, got.steps);
				return;
			end
			want = pending_roots.pop_front();
			if (got != want) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected root %0d status %0d steps %0d,",
						" got root %0d status %0d steps %0d"},
						want.root, want.status, want.steps,
						got.root, got.status, got.steps);
			end
		endfunction

		function int pending();
			return pending_roots.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [IN_BYTES_W-1:0]           s_axis_tdata = '0;  // value
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata;       // root, steps_used
	logic                            m_axis_tuser;       // status
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0]      cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]       cfg_data = '0;

	sqrt_scoreboard sb;

	// sender burst state: items left in this burst and the gap before the next
	int burst_left = 0;
	int gap_cycles = 0;

	newton_square_root_unit #(
		.VALUE_WIDTH(VALUE_W),
		.FRAC_BITS  (FRAC_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
	end

	// result side: every accepted transfer is checked against the oldest root
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// receiver stall pattern: free-running stretches, random toggling, long holds
	initial begin
		int mode;
		int mode_left;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = (mode == 2) ? $urandom_range(1, 40) : $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= 1'b0;
			endcase
		end
	end

	// watchdog: too long without any transfer on any channel ends the run
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[newton_square_root_unit] ERROR");
		$finish;
	end

	// one operand transfer, with bursts and gaps decided here
	task automatic send_operand(input logic [VALUE_W-1:0] value);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end else begin
			gap_cycles = 0;
		end
		if (gap_cycles > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap_cycles) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_BYTES_W'(value);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_operand(value);
		burst_left--;
	endtask

	// stop sending and let every expected root come back before touching registers
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
			input logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [TOL_WIDTH-1:0] tol, input logic [ITER_WIDTH-1:0] iters);
		drain_results();
		write_register(REG_TOLERANCE, CFG_DATA_WIDTH'(tol));
		write_register(REG_MAX_ITERATIONS, CFG_DATA_WIDTH'(iters));
	endtask

	// operand mix: negatives, tiny and small values, exact squares, near-full scale, uniform
	function automatic logic [VALUE_W-1:0] pick_operand();
		int sel;
		int k;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return $urandom | 32'h8000_0000;
		else if (sel < 15)
			return $urandom_range(0, 3);
		else if (sel < 35)
			return $urandom_range(4, 32'h0002_0000);
		else if (sel < 50) begin
			k = $urandom_range(0, 181);
			return (k * k) << FRAC_W;
		end else if (sel < 60)
			return 32'h7fff_0000 | $urandom_range(0, 16'hffff);
		else if (sel < 80)
			return $urandom & 32'h7fff_ffff;
		else
			return $urandom;
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_operand(pick_operand());
	endtask

	initial begin
		logic [TOL_WIDTH-1:0]  tol;
		logic [ITER_WIDTH-1:0] iters;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed part at reset settings: zero, the too-small operand 1 whose first guess
		// is zero, 2 and 3, exact squares, full scale, two other values and negatives
		send_operand(32'h0000_0000);
		send_operand(32'h0000_0001);
		send_operand(32'h0000_0002);
		send_operand(32'h0000_0003);
		send_operand(32'h0001_0000);
		send_operand(32'h0004_0000);
		send_operand(32'h0000_ffff);
		send_operand(32'h4000_0000);
		send_operand(32'h7fff_ffff);
		send_operand(32'h1234_5678);
		send_operand(32'h8000_0000);
		send_operand(32'hffff_ffff);
		send_operand(32'hc000_0000);

		// one step only: large operands leave a guess above the root range
		configure(16'd0, 8'd1);
		send_operand(32'h7fff_ffff);
		send_operand(32'h4000_0000);
		send_operand(32'h0000_0005);

		// no steps allowed: the first guess is the root
		configure(16'd0, 8'd0);
		send_operand(32'h0004_0000);
		send_operand(32'h0000_0001);
		send_operand(32'h8000_0001);
		run_random(17);

		// loosest threshold with the deepest iteration bound
		configure(16'hffff, 8'd255);
		send_operand(32'h7fff_ffff);
		send_operand(32'h0000_0003);
		run_random(58);

		// back to the reset values, written explicitly this time
		configure(TOLERANCE_RESET, MAX_ITERATIONS_RESET);
		run_random(120);

		configure(16'd0, 8'd1);
		run_random(60);

		// zero threshold never converges, so every nonnegative item with a nonzero first guess runs all 255 steps
		configure(16'd0, 8'd255);
		run_random(8);

		configure(16'd1, 8'd20);
		run_random(30);

		// random settings, short iteration bounds where the threshold is tight
		repeat (6) begin
			tol = ($urandom_range(0, 1) == 0) ? TOL_WIDTH'($urandom_range(0, 64))
			                                  : TOL_WIDTH'($urandom_range(0, 16'hffff));
			iters = (tol < 2) ? ITER_WIDTH'($urandom_range(1, 32))
			                  : ITER_WIDTH'($urandom_range(1, 255));
			configure(tol, iters);
			run_random(40);
		end

		drain_results();
		repeat (60) @(posedge clk);
		if (sb.pending() != 0)
			sb.failures++;

		if (sb.failures == 0)
			$display("[newton_square_root_unit] OK");
		else
			$display("[newton_square_root_unit] ERROR");
		$finish;
	end

endmodule
